// File: sv/tlb_pkg.sv
// Shared types and constants of the translation buffer.
package tlb_pkg;

  localparam int DEF_ENTRIES = 64;
  localparam int NUM_PIDS    = 8;
  localparam int PID_IDX_W   = $clog2(NUM_PIDS);
  localparam int CFG_ADDR_W  = PID_IDX_W + 2;
  localparam int SLOT_W      = 6;
  localparam int SLOT_CMP_W  = 9;
  localparam int ADDR_W      = 64;
  localparam int PID_W       = 32;
  localparam int PHYS_HI     = 51;
  localparam int PHYS_LO     = 32;
  localparam logic [ADDR_W-1:0] IO_LIMIT = 64'd1024;

  typedef enum logic [1:0] {
    OP_TRANSLATE = 2'd0,
    OP_PURGE     = 2'd1,
    OP_WRITE     = 2'd2,
    OP_READ      = 2'd3
  } tlb_op_t;

  typedef enum logic [1:0] {
    TRAP_NONE = 2'd0,
    TRAP_PRIV = 2'd1,
    TRAP_MISS = 2'd2,
    TRAP_PROT = 2'd3
  } tlb_trap_t;

  typedef struct packed {
    tlb_op_t           opcode;
    logic [ADDR_W-1:0] virt_addr;
    logic [SLOT_W-1:0] slot;
    logic              new_valid;
    logic [ADDR_W-1:0] new_virt;
    logic [ADDR_W-1:0] new_phys;
    logic [PID_W-1:0]  new_pid;
    logic              privileged;
  } tlb_req_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] hit_phys;
    logic [PID_W-1:0]  hit_pid;
    logic              rd_valid;
    logic [ADDR_W-1:0] rd_virt;
    logic [ADDR_W-1:0] rd_phys;
    logic [PID_W-1:0]  rd_pid;
  } tlb_cam_rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] phys_addr;
    tlb_trap_t         trap;
    logic              is_io;
    logic              rd_valid;
    logic [ADDR_W-1:0] rd_virt;
    logic [ADDR_W-1:0] rd_phys;
    logic [PID_W-1:0]  rd_pid;
  } tlb_res_t;

endpackage

// File: sv/tlb_in_if.sv
// Input channel of the translation buffer.
interface tlb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] virt_addr;
  logic [5:0]  slot;
  logic        new_valid;
  logic [63:0] new_virt;
  logic [63:0] new_phys;
  logic [31:0] new_pid;
  logic        privileged;

  modport source (output valid, opcode, virt_addr, slot, new_valid, new_virt, new_phys,
                  new_pid, privileged, input ready);
  modport sink (input valid, opcode, virt_addr, slot, new_valid, new_virt, new_phys,
                new_pid, privileged, output ready);
endinterface

// File: sv/tlb_out_if.sv
// Result channel of the translation buffer.
interface tlb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] phys_addr;
  logic [1:0]  trap;
  logic        is_io;
  logic        rd_valid;
  logic [63:0] rd_virt;
  logic [63:0] rd_phys;
  logic [31:0] rd_pid;

  modport source (output valid, phys_addr, trap, is_io, rd_valid, rd_virt, rd_phys, rd_pid,
                  input ready);
  modport sink (input valid, phys_addr, trap, is_io, rd_valid, rd_virt, rd_phys, rd_pid,
                output ready);
endinterface

// File: sv/tlb_address_translation.sv
// Top level of the fully associative translation buffer.
// The block takes one item per cycle unless the output stalls. The item is held in an
// input register, every entry is compared with its address in parallel, and the result
// is held in an output register until it is taken. Entry writes and purges take effect
// as the item moves to the output register, so the next item always sees them. Reset
// clears every valid bit at once; there is no clearing pass, and an entry read before
// it was ever written returns undefined address fields. The protection identifiers must
// be written through the APB port while the block is idle; the block does not check.
module tlb_address_translation
  import tlb_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tlb_in_if.sink                in_chan,
  tlb_out_if.source             out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [PID_W-1:0] prot_id [NUM_PIDS];

  logic         s1_valid_r;
  logic         s1_valid_nxt;
  tlb_req_t     s1_req_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  tlb_res_t     res_r;
  tlb_res_t     res_nxt;
  logic         advance;
  logic         in_acc;
  tlb_cam_rsp_t cam_rsp;
  logic         pid_ok;
  logic         phys_region;

  tlb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .prot_id (prot_id)
  );

  tlb_cam #(
    .ENTRIES (ENTRIES)
  ) u_cam (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (s1_req_r),
    .commit (advance),
    .rsp    (cam_rsp)
  );

  assign advance        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || advance;
  assign in_acc         = in_chan.valid && in_chan.ready;
  assign s1_valid_nxt   = in_acc ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt  = advance ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  assign phys_region    = (s1_req_r.virt_addr[PHYS_HI:PHYS_LO] == '0);

  always_comb begin
    pid_ok = 1'b0;
    for (int k = 0; k < NUM_PIDS; k++) begin
      pid_ok = pid_ok | (prot_id[k] == cam_rsp.hit_pid);
    end
  end

  always_comb begin
    res_nxt = '0;
    unique case (s1_req_r.opcode)
      OP_TRANSLATE: begin
        if (phys_region) begin
          if (!s1_req_r.privileged) begin
            res_nxt.trap = TRAP_PRIV;
          end else begin
            res_nxt.phys_addr = s1_req_r.virt_addr;
          end
        end else if (!cam_rsp.hit) begin
          res_nxt.trap = TRAP_MISS;
        end else if (s1_req_r.privileged && !pid_ok) begin
          res_nxt.trap = TRAP_PROT;
        end else begin
          res_nxt.phys_addr = cam_rsp.hit_phys;
        end
        res_nxt.is_io = (res_nxt.trap == TRAP_NONE) && (res_nxt.phys_addr > IO_LIMIT);
      end
      OP_READ: begin
        res_nxt.rd_valid = cam_rsp.rd_valid;
        res_nxt.rd_virt  = cam_rsp.rd_virt;
        res_nxt.rd_phys  = cam_rsp.rd_phys;
        res_nxt.rd_pid   = cam_rsp.rd_pid;
      end
      OP_PURGE, OP_WRITE: begin
        res_nxt = '0;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r.opcode     <= tlb_op_t'(in_chan.opcode);
      s1_req_r.virt_addr  <= in_chan.virt_addr;
      s1_req_r.slot       <= in_chan.slot;
      s1_req_r.new_valid  <= in_chan.new_valid;
      s1_req_r.new_virt   <= in_chan.new_virt;
      s1_req_r.new_phys   <= in_chan.new_phys;
      s1_req_r.new_pid    <= in_chan.new_pid;
      s1_req_r.privileged <= in_chan.privileged;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.phys_addr = res_r.phys_addr;
  assign out_chan.trap      = res_r.trap;
  assign out_chan.is_io     = res_r.is_io;
  assign out_chan.rd_valid  = res_r.rd_valid;
  assign out_chan.rd_virt   = res_r.rd_virt;
  assign out_chan.rd_phys   = res_r.rd_phys;
  assign out_chan.rd_pid    = res_r.rd_pid;

endmodule

// File: sv/tlb_cfg_regs.sv
// APB register bank holding the eight allowed protection identifiers.
module tlb_cfg_regs
  import tlb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [PID_W-1:0]      prot_id [NUM_PIDS]
);

  logic [PID_W-1:0]     prot_id_r [NUM_PIDS];
  logic [PID_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign prdata  = prot_id_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PIDS; k++) begin
        prot_id_r[k] <= '0;
      end
    end else if (wr_en) begin
      prot_id_r[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PIDS; k++) begin
      prot_id[k] = prot_id_r[k];
    end
  end

endmodule

// File: sv/tlb_cam.sv
// Entry array with parallel virtual address match, indexed access and update.
module tlb_cam
  import tlb_pkg::*;
#(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  tlb_req_t     req,
  input  logic         commit,
  output tlb_cam_rsp_t rsp
);

  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [ADDR_W-1:0]  virt_r [ENTRIES];
  logic [ADDR_W-1:0]  phys_r [ENTRIES];
  logic [PID_W-1:0]   pid_r  [ENTRIES];

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] first;
  logic [ENTRIES-1:0] sel;
  logic               do_write;
  logic               do_purge;

  assign do_write = commit && (req.opcode == OP_WRITE);
  assign do_purge = commit && (req.opcode == OP_PURGE);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (virt_r[i] == req.virt_addr);
      sel[i]   = ({{(SLOT_CMP_W - SLOT_W){1'b0}}, req.slot} == SLOT_CMP_W'(i));
    end
  end

  // The lowest matching entry wins.
  assign first = match & (~match + ENTRIES'(1));

  always_comb begin
    rsp          = '0;
    rsp.hit      = |match;
    rsp.rd_valid = |(sel & valid_r);
    for (int i = 0; i < ENTRIES; i++) begin
      rsp.hit_phys = rsp.hit_phys | (phys_r[i] & {ADDR_W{first[i]}});
      rsp.hit_pid  = rsp.hit_pid  | (pid_r[i]  & {PID_W{first[i]}});
      rsp.rd_virt  = rsp.rd_virt  | (virt_r[i] & {ADDR_W{sel[i]}});
      rsp.rd_phys  = rsp.rd_phys  | (phys_r[i] & {ADDR_W{sel[i]}});
      rsp.rd_pid   = rsp.rd_pid   | (pid_r[i]  & {PID_W{sel[i]}});
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_write && sel[i]) begin
        valid_nxt[i] = req.new_valid;
      end else if (do_purge && match[i]) begin
        valid_nxt[i] = 1'b0;
      end else begin
        valid_nxt[i] = valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_write && sel[i]) begin
        virt_r[i] <= req.new_virt;
        phys_r[i] <= req.new_phys;
        pid_r[i]  <= req.new_pid;
      end
    end
  end

endmodule

// File: tb/tb_tlb_address_translation.sv
// Self-checking testbench for the translation buffer: directed corners, random traffic, APB setup.
module tb_tlb_address_translation
  import tlb_pkg::*;
();

  localparam int ENTRIES      = DEF_ENTRIES;
  localparam int REG_STRIDE   = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 6;
  localparam int POOL_SIZE    = 16;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  tlb_in_if in_chan ();
  tlb_out_if out_chan ();

  tlb_address_translation #(.ENTRIES(ENTRIES)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // Shadow copy of the buffer and of the allowed protection identifiers.
  logic             tlb_valid [ENTRIES];
  logic [63:0]      tlb_virt [ENTRIES];
  logic [63:0]      tlb_phys [ENTRIES];
  logic [31:0]      tlb_pid [ENTRIES];
  logic [31:0]      prot_ids [NUM_PIDS];
  bit               slot_written [ENTRIES];
  int               written_slots [$];
  logic [63:0]      va_pool [$];
  tlb_res_t         pending_results [$];

  int          mismatch_count = 0;
  int          op_tally [4] = '{0, 0, 0, 0};
  int          trap_tally [4] = '{0, 0, 0, 0};
  int          settings_count = 1;
  bit          no_idling = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned quiet_cycles = 0;

  function automatic int pick_gap();
    int roll;
    if (no_idling) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic tlb_res_t predict_result(input tlb_req_t req);
    tlb_res_t res;
    int hit;
    bit pid_ok;
    res = '0;
    hit = -1;
    pid_ok = 1'b0;
    op_tally[req.opcode]++;
    case (req.opcode)
      OP_TRANSLATE: begin
        if (req.virt_addr[PHYS_HI:PHYS_LO] == '0) begin
          if (req.privileged) res.phys_addr = req.virt_addr;
          else res.trap = TRAP_PRIV;
        end else begin
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (tlb_valid[i] && tlb_virt[i] == req.virt_addr) hit = i;
          end
          if (hit < 0) begin
            res.trap = TRAP_MISS;
          end else begin
            for (int k = 0; k < NUM_PIDS; k++) begin
              if (prot_ids[k] == tlb_pid[hit]) pid_ok = 1'b1;
            end
            if (req.privileged && !pid_ok) res.trap = TRAP_PROT;
            else res.phys_addr = tlb_phys[hit];
          end
        end
        res.is_io = (res.trap == TRAP_NONE) && (res.phys_addr > IO_LIMIT);
        trap_tally[res.trap]++;
      end
      OP_PURGE: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tlb_valid[i] && tlb_virt[i] == req.virt_addr) tlb_valid[i] = 1'b0;
        end
      end
      OP_WRITE: begin
        if (req.slot < ENTRIES) begin
          tlb_valid[req.slot] = req.new_valid;
          tlb_virt[req.slot]  = req.new_virt;
          tlb_phys[req.slot]  = req.new_phys;
          tlb_pid[req.slot]   = req.new_pid;
        end
      end
      default: begin
        if (req.slot < ENTRIES) begin
          res.rd_valid = tlb_valid[req.slot];
          res.rd_virt  = tlb_virt[req.slot];
          res.rd_phys  = tlb_phys[req.slot];
          res.rd_pid   = tlb_pid[req.slot];
        end
      end
    endcase
    return res;
  endfunction

  task automatic send_item(input tlb_req_t req);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.opcode     = req.opcode;
    in_chan.virt_addr  = req.virt_addr;
    in_chan.slot       = req.slot;
    in_chan.new_valid  = req.new_valid;
    in_chan.new_virt   = req.new_virt;
    in_chan.new_phys   = req.new_phys;
    in_chan.new_pid    = req.new_pid;
    in_chan.privileged = req.privileged;
    in_chan.valid      = 1'b1;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_results.push_back(predict_result(req));
  endtask

  function automatic tlb_req_t noise_item();
    tlb_req_t r;
    r.opcode     = tlb_op_t'($urandom_range(0, 3));
    r.virt_addr  = {$urandom, $urandom};
    r.slot       = SLOT_W'($urandom_range(0, 63));
    r.new_valid  = 1'($urandom_range(0, 1));
    r.new_virt   = {$urandom, $urandom};
    r.new_phys   = {$urandom, $urandom};
    r.new_pid    = $urandom;
    r.privileged = 1'($urandom_range(0, 1));
    return r;
  endfunction

  task automatic translate_item(input logic [63:0] va, input logic priv);
    tlb_req_t r;
    r = noise_item();
    r.opcode = OP_TRANSLATE;
    r.virt_addr = va;
    r.privileged = priv;
    send_item(r);
  endtask

  task automatic purge_item(input logic [63:0] va);
    tlb_req_t r;
    r = noise_item();
    r.opcode = OP_PURGE;
    r.virt_addr = va;
    send_item(r);
  endtask

  task automatic write_item(input logic [5:0] slot, input logic valid, input logic [63:0] virt,
                            input logic [63:0] phys, input logic [31:0] pid);
    tlb_req_t r;
    r = noise_item();
    r.opcode = OP_WRITE;
    r.slot = slot;
    r.new_valid = valid;
    r.new_virt = virt;
    r.new_phys = phys;
    r.new_pid = pid;
    if (!slot_written[slot]) begin
      slot_written[slot] = 1'b1;
      written_slots.push_back(int'(slot));
    end
    send_item(r);
  endtask

  task automatic read_item(input logic [5:0] slot);
    tlb_req_t r;
    r = noise_item();
    r.opcode = OP_READ;
    r.slot = slot;
    send_item(r);
  endtask

  function automatic logic [63:0] fresh_mapped_va();
    logic [63:0] va;
    va = {$urandom, $urandom};
    if (va[PHYS_HI:PHYS_LO] == '0) va[45] = 1'b1;
    return va;
  endfunction

  function automatic logic [63:0] physical_va();
    logic [63:0] va;
    va = {$urandom, $urandom};
    va[PHYS_HI:PHYS_LO] = '0;
    if ($urandom_range(0, 3) == 0) va = 64'($urandom_range(1015, 1035));
    return va;
  endfunction

  function automatic logic [63:0] pool_va();
    logic [63:0] va;
    if (va_pool.size() == 0) begin
      va = fresh_mapped_va();
      va_pool.push_back(va);
      return va;
    end
    return va_pool[$urandom_range(0, va_pool.size() - 1)];
  endfunction

  function automatic void add_to_pool(input logic [63:0] va);
    if (va_pool.size() < POOL_SIZE) va_pool.push_back(va);
    else va_pool[$urandom_range(0, POOL_SIZE - 1)] = va;
  endfunction

  task automatic random_item();
    int roll;
    int pick;
    logic [63:0] va;
    logic [63:0] phys;
    logic [31:0] pid;
    roll = $urandom_range(0, 99);
    if (roll < 25 || written_slots.size() == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        va = pool_va();
      end else if (pick < 90) begin
        va = fresh_mapped_va();
        add_to_pool(va);
      end else begin
        va = {$urandom, $urandom};
      end
      phys = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(1000, 1050)) : {$urandom, $urandom};
      pid = ($urandom_range(0, 9) < 6) ? prot_ids[$urandom_range(0, NUM_PIDS - 1)] : $urandom;
      write_item(SLOT_W'($urandom_range(0, 63)), $urandom_range(0, 9) != 0, va, phys, pid);
    end else if (roll < 65) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) va = pool_va();
      else if (pick < 80) va = physical_va();
      else va = {$urandom, $urandom};
      translate_item(va, 1'($urandom_range(0, 1)));
    end else if (roll < 75) begin
      purge_item(($urandom_range(0, 4) != 0) ? pool_va() : fresh_mapped_va());
    end else begin
      read_item(SLOT_W'(written_slots[$urandom_range(0, written_slots.size() - 1)]));
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_prot_id(input int idx, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = CFG_ADDR_W'(REG_STRIDE * idx);
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    prot_ids[idx] = value;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic program_prot_ids(input logic [31:0] ids [NUM_PIDS]);
    drain_results();
    for (int k = 0; k < NUM_PIDS; k++) write_prot_id(k, ids[k]);
    settings_count++;
  endtask

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_result();
    tlb_res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: expected no result, got phys_addr %h trap %0d", $time,
               out_chan.phys_addr, out_chan.trap);
      mismatch_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("phys_addr", want.phys_addr, out_chan.phys_addr);
      compare_field("trap", 64'(want.trap), 64'(out_chan.trap));
      compare_field("is_io", 64'(want.is_io), 64'(out_chan.is_io));
      compare_field("rd_valid", 64'(want.rd_valid), 64'(out_chan.rd_valid));
      compare_field("rd_virt", want.rd_virt, out_chan.rd_virt);
      compare_field("rd_phys", want.rd_phys, out_chan.rd_phys);
      compare_field("rd_pid", 64'(want.rd_pid), 64'(out_chan.rd_pid));
    end
  endtask

  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) check_result();
    end
  end

  initial begin : result_throttle
    int stall;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_chan.ready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        hold_off_req = 1'b0;
        out_chan.ready = 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_chan.ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_chan.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Timeout: no item moved for %0d cycles.", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic test_directed_corners();
    logic [63:0] va_a;
    logic [63:0] va_b;
    logic [63:0] va_c;
    logic [63:0] va_d;
    va_a = 64'h0000_0001_0000_0000;
    va_b = 64'hFFFF_FFFF_FFFF_FFFF;
    va_c = 64'h000F_FFFF_0000_0000;
    va_d = 64'h8000_1000_0000_0000;
    translate_item(64'd0, 1'b1);
    translate_item(64'd1024, 1'b1);
    translate_item(64'd1025, 1'b1);
    translate_item(64'hFFF0_0000_FFFF_FFFF, 1'b1);
    translate_item(64'h0000_0000_1234_5678, 1'b0);
    translate_item(va_a, 1'b1);
    write_item(6'd0, 1'b1, va_a, 64'd1025, 32'd0);
    translate_item(va_a, 1'b1);
    write_item(6'd63, 1'b1, va_b, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    translate_item(va_b, 1'b1);
    translate_item(va_b, 1'b0);
    write_item(6'd10, 1'b1, va_c, 64'd1024, 32'd0);
    write_item(6'd3, 1'b1, va_c, 64'd5, 32'd0);
    translate_item(va_c, 1'b1);
    write_item(6'd20, 1'b0, va_d, 64'd99, 32'd0);
    translate_item(va_d, 1'b0);
    purge_item(va_c);
    translate_item(va_c, 1'b0);
    read_item(6'd3);
    read_item(6'd63);
    read_item(6'd0);
    read_item(6'd20);
    purge_item(64'h0000_0000_0000_1234);
    translate_item(va_a, 1'b0);
    add_to_pool(va_a);
    add_to_pool(va_b);
    add_to_pool(va_c);
  endtask

  task automatic test_all_ones_ids();
    logic [31:0] ids [NUM_PIDS];
    foreach (ids[k]) ids[k] = 32'hFFFF_FFFF;
    program_prot_ids(ids);
    translate_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    translate_item(64'h0000_0001_0000_0000, 1'b1);
    translate_item(64'h0000_0001_0000_0000, 1'b0);
  endtask

  task automatic test_random_traffic(input int count);
    logic [31:0] ids [NUM_PIDS];
    foreach (ids[k]) ids[k] = $urandom;
    program_prot_ids(ids);
    repeat (count) random_item();
  endtask

  task automatic test_mixed_ids_no_idle(input int count);
    logic [31:0] ids [NUM_PIDS];
    foreach (ids[k]) ids[k] = (k % 3 == 0) ? 32'd0 : ((k % 3 == 1) ? 32'hFFFF_FFFF : $urandom);
    program_prot_ids(ids);
    no_idling = 1'b1;
    repeat (count) random_item();
    no_idling = 1'b0;
  endtask

  task automatic test_backpressure(input int count);
    hold_off_req = 1'b1;
    repeat (count) random_item();
  endtask

  task automatic test_entry_pid_ids(input int count);
    logic [31:0] ids [NUM_PIDS];
    foreach (ids[k]) ids[k] = tlb_pid[written_slots[$urandom_range(0, written_slots.size() - 1)]];
    program_prot_ids(ids);
    repeat (count) random_item();
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.opcode = OP_TRANSLATE;
    in_chan.virt_addr = '0;
    in_chan.slot = '0;
    in_chan.new_valid = 1'b0;
    in_chan.new_virt = '0;
    in_chan.new_phys = '0;
    in_chan.new_pid = '0;
    in_chan.privileged = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    foreach (tlb_valid[i]) begin
      tlb_valid[i] = 1'b0;
      tlb_virt[i] = '0;
      tlb_phys[i] = '0;
      tlb_pid[i] = '0;
      slot_written[i] = 1'b0;
    end
    foreach (prot_ids[k]) prot_ids[k] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_corners();
    test_all_ones_ids();
    test_random_traffic(500);
    test_mixed_ids_no_idle(300);
    test_backpressure(100);
    test_entry_pid_ids(500);
    test_random_traffic(500);
    drain_results();

    $display("Run covered %0d items: %0d translations, %0d purges, %0d entry writes, %0d reads.",
             op_tally[OP_TRANSLATE] + op_tally[OP_PURGE] + op_tally[OP_WRITE] + op_tally[OP_READ],
             op_tally[OP_TRANSLATE], op_tally[OP_PURGE], op_tally[OP_WRITE], op_tally[OP_READ]);
    $display("Translations: %0d clean, %0d privilege, %0d miss, %0d protection; %0d ID sets.",
             trap_tally[TRAP_NONE], trap_tally[TRAP_PRIV], trap_tally[TRAP_MISS],
             trap_tally[TRAP_PROT], settings_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: tlb_address_translation.f
sv/tlb_pkg.sv
sv/tlb_in_if.sv
sv/tlb_out_if.sv
sv/tlb_cfg_regs.sv
sv/tlb_cam.sv
sv/tlb_address_translation.sv
tb/tb_tlb_address_translation.sv
